// ===== hw/rtl/descending_key_insertion_sorter_macros.svh =====
// assertion macros for the descending key insertion sorter
// depends on clk and rst_n being visible in the module that uses them
`ifndef DESCENDING_KEY_INSERTION_SORTER_MACROS_SVH
`define DESCENDING_KEY_INSERTION_SORTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DKIS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dkis same-cycle check failed");

// next-cycle implication, checked outside reset
`define DKIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dkis next-cycle check failed");

`endif

// ===== hw/rtl/dkis_pkg.sv =====
// shared types and constants for the descending key insertion sorter
// no dependencies
`timescale 1ns / 1ps

package dkis_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 8;

    // one rank slot as seen by its neighbors
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    // row-wide strobes
    typedef struct packed {
        logic insert;
        logic pop;
    } ctrl_t;

endpackage

// ===== hw/rtl/dkis_cell.sv =====
// one rank cell of the sorting row: compare, shift down on insert, shift up on pop
// depends on dkis_pkg
`timescale 1ns / 1ps

module dkis_cell
    import dkis_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_t               ctrl,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [TAG_BITS-1:0] new_tag,
    input  logic                prev_take,
    input  entry_t              prev_entry,
    input  entry_t              next_entry,
    output logic                take,
    output entry_t              entry
);

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    // new item belongs at or above this rank
    assign take  = !valid_reg || (key_reg < new_key);
    assign entry = '{valid: valid_reg, key: key_reg, tag: tag_reg};

    always_comb
    begin
        priority if (ctrl.insert && take)
        begin
            if (prev_take)
            begin
                valid_next = prev_entry.valid;
                key_next   = prev_entry.key;
                tag_next   = prev_entry.tag;
            end
            else
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                tag_next   = new_tag;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = next_entry.valid;
            key_next   = next_entry.key;
            tag_next   = next_entry.tag;
        end
        else
        begin
            valid_next = valid_reg;
            key_next   = key_reg;
            tag_next   = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

// ===== hw/rtl/descending_key_insertion_sorter.sv =====
// top level of the descending key insertion sorter: row of rank cells plus drain control
// depends on dkis_pkg, dkis_cell and descending_key_insertion_sorter_macros.svh
`timescale 1ns / 1ps
//
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   key, tag, last
// output    out        out_valid / out_stall sorted_key, sorted_tag, end_of_list, overflow
//
// an item without last is inserted when accepted; items can follow back to back while no drain runs
// an item with last is inserted likewise, then the list drains one rank per
// accepted output, with the input stalled meanwhile
// the drain shifts the cell row up by one rank each time an output is taken
// reset clears the cell valid bits, the drain flag and the overflow flag
// a stalled output holds, since the row only shifts on an accepted item

`include "descending_key_insertion_sorter_macros.svh"

module descending_key_insertion_sorter
    import dkis_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KEY_BITS-1:0] key,
    input  logic [TAG_BITS-1:0] tag,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [KEY_BITS-1:0] sorted_key,
    output logic [TAG_BITS-1:0] sorted_tag,
    output logic                end_of_list,
    output logic                overflow
);

    logic        drain_reg;
    logic        drain_next;
    logic        overflowed_reg;
    logic        overflowed_next;
    ctrl_t       ctrl;
    logic        in_acc;
    logic        out_acc;
    entry_t      cell_entry [DEPTH];
    logic        cell_take  [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    logic [DEPTH-1:0] valid_inc;

    // handshake: input stalls for the whole drain
    assign in_stall  = drain_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = drain_reg && cell_entry[0].valid;
    assign out_acc   = out_valid && !out_stall;

    assign ctrl = '{insert: in_acc, pop: out_acc};

    // head of the row is the next result
    assign sorted_key  = cell_entry[0].key;
    assign sorted_tag  = cell_entry[0].tag;
    assign end_of_list = !cell_entry[1].valid;
    assign overflow    = overflowed_reg;

    // the rank cells, each talking to its neighbors only
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   prev_take;
        entry_t prev_entry;
        entry_t next_entry;

        if (i == 0)
        begin : g_head
            assign prev_take  = 1'b0;
            assign prev_entry = '0;
        end
        else
        begin : g_body
            assign prev_take  = cell_take[i-1];
            assign prev_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_entry = '0;
        end
        else
        begin : g_inner
            assign next_entry = cell_entry[i+1];
        end

        dkis_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_key    (key),
            .new_tag    (tag),
            .prev_take  (prev_take),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .take       (cell_take[i]),
            .entry      (cell_entry[i])
        );

        assign valid_vec[i] = cell_entry[i].valid;
    end

    assign valid_inc = valid_vec + DEPTH'(1);

    // drain control and the sticky drop flag
    always_comb
    begin
        drain_next      = drain_reg;
        overflowed_next = overflowed_reg;
        priority if (in_acc)
        begin
            // a full row drops one entry on every insert
            if (cell_entry[DEPTH-1].valid)
            begin
                overflowed_next = 1'b1;
            end
            if (last)
            begin
                drain_next = 1'b1;
            end
        end
        else if (out_acc && end_of_list)
        begin
            drain_next      = 1'b0;
            overflowed_next = 1'b0;
        end
        else
        begin
            drain_next      = drain_reg;
            overflowed_next = overflowed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg      <= 1'b0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            drain_reg      <= drain_next;
            overflowed_reg <= overflowed_next;
        end
    end

    // valid ranks always form a prefix of the row
    `DKIS_ASSERT_IMP(a_valid_prefix, 1'b1, (valid_vec & valid_inc) == '0)
    // the first two valid ranks are in descending key order
    `DKIS_ASSERT_IMP(a_row_sorted, cell_entry[1].valid, cell_entry[0].key >= cell_entry[1].key)
    // a last item starts a drain with at least one rank
    `DKIS_ASSERT_NEXT(a_last_drains, in_acc && last, drain_reg && cell_entry[0].valid)
    // taking the final rank empties the row and leaves drain mode
    `DKIS_ASSERT_NEXT(a_drain_clears, out_acc && end_of_list,
        !drain_reg && !overflowed_reg && valid_vec == '0)

endmodule
